// File: sv/thl_pkg.sv
// shared types and constants of the two-wire handshake link
package thl_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam int CFG_WIDTH     = 16;
    localparam int TIMEOUT_WIDTH = 16;
    localparam int DELAY_WIDTH   = 8;
    localparam int BYTE_WIDTH    = 8;
    localparam int BIT_CNT_WIDTH = 3;

    // configuration register indexes
    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_DELAY   = 1'b1;

    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [DELAY_WIDTH-1:0]   DELAY_RST   = 8'd0;

    // request kinds
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SEND = 2'd1;
    localparam logic [1:0] REQ_RECV = 2'd2;

    // drive codes
    localparam logic [1:0] DRV_WHITE = 2'd1;
    localparam logic [1:0] DRV_RED   = 2'd2;
    localparam logic [1:0] DRV_REL   = 2'd3;

    // sampled line patterns
    localparam logic [1:0] LINE_RED   = 2'd1;
    localparam logic [1:0] LINE_WHITE = 2'd2;
    localparam logic [1:0] LINES_BOTH = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_SEND = 2'd1;
    localparam logic [1:0] ERR_RECV = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_S_LOW   = 7'b0000010,
        PH_S_HIGH  = 7'b0000100,
        PH_S_DELAY = 7'b0001000,
        PH_R_START = 7'b0010000,
        PH_R_ACK   = 7'b0100000,
        PH_R_DELAY = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [BYTE_WIDTH-1:0] tx_byte;
        logic [1:0]            line_in;
    } t_item;

    typedef struct packed {
        logic                  rx_pending;
        logic                  busy_res;
        logic [1:0]            error_code;
        logic                  done_res;
        logic [BYTE_WIDTH-1:0] rx_byte;
        logic [1:0]            line_drive;
    } t_result;

endpackage

// File: sv/thl_in_stage.sv
// input register stage holding one sampled tick
module thl_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  thl_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_take,
    output thl_pkg::t_item o_item
);
    import thl_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign n_valid = i_valid || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// File: sv/thl_ctrl.sv
// link controller: state, timers and the per-tick step logic
module thl_ctrl #(
    parameter int TIMER_WIDTH = thl_pkg::TIMER_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [thl_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                        i_step,
    input  thl_pkg::t_item              i_item,
    output thl_pkg::t_result            o_result
);
    import thl_pkg::*;

    localparam int LW = (TIMER_WIDTH > TIMEOUT_WIDTH) ? TIMER_WIDTH : TIMEOUT_WIDTH;

    logic [TIMEOUT_WIDTH-1:0] r_timeout;
    logic [DELAY_WIDTH-1:0]   r_bit_delay;

    t_phase                   r_phase, n_phase;
    logic [BIT_CNT_WIDTH-1:0] r_bit_cnt, n_bit_cnt;
    logic [BYTE_WIDTH-1:0]    r_shift, n_shift;
    logic [TIMER_WIDTH-1:0]   r_wait, n_wait;
    logic [DELAY_WIDTH-1:0]   r_delay, n_delay;
    logic [1:0]               r_drive, n_drive;

    logic [LW-1:0]          lim_ext;
    logic [LW-1:0]          to_ext;
    logic [LW-1:0]          tmax_ext;
    logic [TIMER_WIDTH-1:0] lim;
    logic                   expired;
    logic [TIMER_WIDTH-1:0] wait_inc;
    logic [1:0]             mask;
    logic                   bit_end;
    logic                   bit_send;
    logic                   adv;
    logic                   adv_send;
    logic                   done;
    logic [1:0]             err;
    logic [BYTE_WIDTH-1:0]  rx;

    // timeout limit capped at the largest timer value
    assign to_ext   = LW'(r_timeout);
    assign tmax_ext = LW'({TIMER_WIDTH{1'b1}});
    assign lim_ext  = (to_ext > tmax_ext) ? tmax_ext : to_ext;
    assign lim      = lim_ext[TIMER_WIDTH-1:0];
    assign expired  = (r_wait >= lim);
    assign wait_inc = r_wait + TIMER_WIDTH'(1);

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_wait    = r_wait;
        n_delay   = r_delay;
        n_drive   = r_drive;
        mask      = LINE_RED;
        bit_end   = 1'b0;
        bit_send  = 1'b0;
        adv       = 1'b0;
        adv_send  = 1'b0;
        done      = 1'b0;
        err       = ERR_NONE;
        rx        = '0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.req_type == REQ_SEND) begin
                    n_shift   = i_item.tx_byte;
                    n_bit_cnt = '0;
                    n_drive   = i_item.tx_byte[0] ? DRV_RED : DRV_WHITE;
                    n_phase   = PH_S_LOW;
                    n_wait    = '0;
                end else if (i_item.req_type == REQ_RECV) begin
                    n_shift   = '0;
                    n_bit_cnt = '0;
                    n_drive   = DRV_REL;
                    n_phase   = PH_R_START;
                    n_wait    = '0;
                end
            end
            PH_S_LOW: begin
                mask = (r_drive == DRV_RED) ? LINE_RED : LINE_WHITE;
                if ((i_item.line_in & mask) == 2'b00) begin
                    n_drive = DRV_REL;
                    n_phase = PH_S_HIGH;
                    n_wait  = '0;
                end else if (expired) begin
                    done = 1'b1;
                    err  = ERR_SEND;
                end else begin
                    n_wait = wait_inc;
                end
            end
            PH_S_HIGH: begin
                mask = r_shift[0] ? LINE_RED : LINE_WHITE;
                if ((i_item.line_in & mask) != 2'b00) begin
                    bit_end  = 1'b1;
                    bit_send = 1'b1;
                end else if (expired) begin
                    done = 1'b1;
                    err  = ERR_SEND;
                end else begin
                    n_wait = wait_inc;
                end
            end
            PH_R_START: begin
                if (i_item.line_in == LINES_BOTH) begin
                    if (expired) begin
                        done = 1'b1;
                        err  = ERR_RECV;
                    end else begin
                        n_wait = wait_inc;
                    end
                end else begin
                    // red high with white low is a one, anything else a zero
                    if (i_item.line_in == LINE_RED) begin
                        n_shift = {1'b1, r_shift[BYTE_WIDTH-1:1]};
                        n_drive = DRV_WHITE;
                    end else begin
                        n_shift = {1'b0, r_shift[BYTE_WIDTH-1:1]};
                        n_drive = DRV_RED;
                    end
                    n_phase = PH_R_ACK;
                    n_wait  = '0;
                end
            end
            PH_R_ACK: begin
                mask = (r_drive == DRV_WHITE) ? LINE_WHITE : LINE_RED;
                if ((i_item.line_in & mask) != 2'b00) begin
                    bit_end = 1'b1;
                end else if (expired) begin
                    done = 1'b1;
                    err  = ERR_RECV;
                end else begin
                    n_wait = wait_inc;
                end
            end
            PH_S_DELAY, PH_R_DELAY: begin
                n_delay = r_delay - DELAY_WIDTH'(1);
                if (n_delay == '0) begin
                    adv      = 1'b1;
                    adv_send = (r_phase == PH_S_DELAY);
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_drive = DRV_REL;
            end
        endcase

        // end of one bit handshake
        if (bit_end) begin
            n_drive   = DRV_REL;
            n_bit_cnt = r_bit_cnt + BIT_CNT_WIDTH'(1);
            if (bit_send) begin
                n_shift = {1'b0, r_shift[BYTE_WIDTH-1:1]};
            end
            if (r_bit_delay != '0) begin
                n_delay = r_bit_delay;
                n_phase = bit_send ? PH_S_DELAY : PH_R_DELAY;
            end else begin
                adv      = 1'b1;
                adv_send = bit_send;
            end
        end

        // move on to the next bit or close the byte
        if (adv) begin
            if (n_bit_cnt == '0) begin
                done = 1'b1;
                rx   = adv_send ? '0 : n_shift;
            end else if (adv_send) begin
                n_drive = n_shift[0] ? DRV_RED : DRV_WHITE;
                n_phase = PH_S_LOW;
                n_wait  = '0;
            end else begin
                n_drive = DRV_REL;
                n_phase = PH_R_START;
                n_wait  = '0;
            end
        end

        if (done) begin
            n_phase = PH_IDLE;
            n_drive = DRV_REL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_bit_delay <= DELAY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data[TIMEOUT_WIDTH-1:0];
            end else begin
                r_bit_delay <= i_cfg_data[DELAY_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_wait    <= '0;
            r_delay   <= '0;
            r_drive   <= DRV_REL;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_delay   <= n_delay;
            r_drive   <= n_drive;
        end
    end

    assign o_result.line_drive = n_drive;
    assign o_result.rx_byte    = rx;
    assign o_result.done_res   = done;
    assign o_result.error_code = err;
    assign o_result.busy_res   = (n_phase != PH_IDLE);
    assign o_result.rx_pending = (n_phase == PH_IDLE) && (i_item.line_in != LINES_BOTH);
endmodule

// File: sv/thl_out_stage.sv
// result register stage facing the downstream side
module thl_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  thl_pkg::t_result i_result,
    output logic             o_valid,
    input  logic             i_ready,
    output thl_pkg::t_result o_result
);
    import thl_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = i_valid || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

// File: sv/two_wire_handshake_link.sv
// top level of the two-wire handshake byte link controller
//
//  channel   dir  beat contents
//  s_axis    in   tdata: tx_byte[7:0], line_in[9:8]; tuser: req_type[1:0]
//  m_axis    out  tdata: line_drive[1:0], rx_byte[9:2], done_res[10],
//                 error_code[12:11], busy_res[13], rx_pending[14]
//  cfg       in   i_cfg_idx 0 timeout_ticks, 1 bit_delay_ticks
//
// one beat in and one beat out per cycle while m_axis is not stalled; a beat taken
// on s_axis passes through the input register, then the result register, to m_axis.
// the controller state steps only when a tick moves into the result register.
// reset is synchronous and leaves the lines released with no transfer pending.
// a stall on m_axis backs up through both registers to s_axis_tready.
module two_wire_handshake_link #(
    parameter int TIMER_WIDTH = thl_pkg::TIMER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [thl_pkg::CFG_WIDTH-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // tx_byte, line_in
    input  logic [1:0]                    s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // line_drive, rx_byte, done_res, error_code, busy_res, rx_pending
    output logic [15:0]                   m_axis_tdata
);
    import thl_pkg::*;

    t_item   in_item;
    t_item   stg_item;
    t_result step_result;
    t_result out_result;
    logic    stg_valid;
    logic    out_ready;
    logic    step;

    assign in_item.req_type = s_axis_tuser;
    assign in_item.tx_byte  = s_axis_tdata[7:0];
    assign in_item.line_in  = s_axis_tdata[9:8];

    assign step = stg_valid && out_ready;

    thl_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (stg_valid),
        .i_take  (step),
        .o_item  (stg_item)
    );

    thl_ctrl #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_item     (stg_item),
        .o_result   (step_result)
    );

    thl_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stg_valid),
        .o_ready  (out_ready),
        .i_result (step_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {1'b0, out_result};

`ifndef ASSERT_OFF
    // an abort always ends the transfer with the lines released
    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && out_result.error_code != ERR_NONE) |->
        (out_result.done_res && !out_result.busy_res && out_result.line_drive == DRV_REL))
        else $error("error beat without a clean finish");

    // a pending receive is only reported while idle
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(out_result.busy_res && out_result.rx_pending))
        else $error("rx_pending while busy");

    // a stepped tick always lands in the result register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("stepped tick lost before the result register");
`endif
endmodule
